// ===== hdl/scene_bounds_sphere_fit_defines.svh =====
// Assertion macros shared by the scene bounds checker.
`ifndef SCENE_BOUNDS_SPHERE_FIT_DEFINES_SVH
`define SCENE_BOUNDS_SPHERE_FIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SBSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SBSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbsf_pkg.sv =====
// Shared constants, codes and types of the scene bounds sphere fit block.
`timescale 1ns / 1ps

package sbsf_pkg;

  // Coordinate width of column components, box corners and centers
  localparam int COORD_WIDTH = 32;

  // Magnitude / side operand width: keeps bits above 32 for square overflow
  localparam int OPER_W = (COORD_WIDTH >= 32) ? COORD_WIDTH + 1 : 33;
  // Corner arithmetic width: coordinate plus or minus a 31-bit extent
  localparam int WIDE_W = OPER_W + 1;

  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ROOT_IN_W  = 64;
  localparam int ROOT_OUT_W = ROOT_IN_W / 2;
  localparam int ROOT_STEPS = ROOT_IN_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam int RADIUS_W   = 31;
  localparam int GAIN_W     = 18;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register reset values: radii unsigned Q15.16, margin gain unsigned Q2.16
  localparam logic [RADIUS_W-1:0] FLOOR_RESET   = RADIUS_W'(786432);
  localparam logic [RADIUS_W-1:0] CEILING_RESET = RADIUS_W'(13107200);
  localparam logic [GAIN_W-1:0]   GAIN_RESET    = GAIN_W'(75366);
  localparam logic [RADIUS_W-1:0] EMPTY_RESET   = RADIUS_W'(786432);

  // Item operation codes
  typedef enum logic {
    OP_COLUMN = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // Column number that carries the translation and completes an object
  localparam logic [1:0] COL_TRANSLATION = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_FLOOR   = 3'd0,
    CFG_RADIUS_CEILING = 3'd1,
    CFG_MARGIN_GAIN    = 3'd2,
    CFG_EMPTY_RADIUS   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius_floor;
    logic [RADIUS_W-1:0] radius_ceiling;
    logic [GAIN_W-1:0]   margin_gain;
    logic [RADIUS_W-1:0] empty_radius;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

// ===== hdl/sbsf_ifs.sv =====
// Valid/ready channel interfaces for column items and scene results.
`timescale 1ns / 1ps

interface sbsf_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic [1:0]                             column_index;
  logic signed [sbsf_pkg::COORD_WIDTH-1:0] col_x;
  logic signed [sbsf_pkg::COORD_WIDTH-1:0] col_y;
  logic signed [sbsf_pkg::COORD_WIDTH-1:0] col_z;

  modport source (output valid, operation, column_index, col_x, col_y, col_z,
                  input ready);
  modport sink   (input valid, operation, column_index, col_x, col_y, col_z,
                  output ready);
endinterface

interface sbsf_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sbsf_pkg::COORD_WIDTH-1:0] center_x;
  logic signed [sbsf_pkg::COORD_WIDTH-1:0] center_y;
  logic signed [sbsf_pkg::COORD_WIDTH-1:0] center_z;
  logic [sbsf_pkg::RADIUS_W-1:0]          bound_radius;
  logic                                   scene_empty;

  modport source (output valid, center_x, center_y, center_z, bound_radius,
                  scene_empty, input ready);
  modport sink   (input valid, center_x, center_y, center_z, bound_radius,
                  scene_empty, output ready);
endinterface

// ===== hdl/scene_bounds_sphere_fit.sv =====
// Scene bounds sphere fit: top level with sequencer, shared multiplier and box.
//
// Usage: column items arrive on the item channel (valid/ready), one matrix
// column each in signed Q16.16. Columns 0 to 2 add their squared lengths to
// the object sum; column 3 completes the object and grows the scene box by a
// cube of half the root of that sum. A finish item emits one result on the
// result channel: box center, clamped radius and an empty flag, then clears.
// Column 0 to 2 items and finish items of a non-empty scene square each
// component in turn on the one shared 32x32 multiplier. Column 3 items and
// those finish items run the 32-step square root unit.
// One item is in work at a time; ready is high only while the block is idle.
// The result sits in an output register; a finish waits there only while an
// earlier result has not been taken. Column items never wait on the result.
// Reset is synchronous: it clears the sequencer, scene state and result
// channel and loads register defaults. The user writes registers through
// write_enable/reg_index/write_data only while the block is idle (unchecked).
`timescale 1ns / 1ps

module scene_bounds_sphere_fit (
  input  logic                            clk,
  input  logic                            rst,
  sbsf_item_if.sink                       item,
  sbsf_result_if.source                   result,
  input  logic                            write_enable,
  input  logic [sbsf_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [sbsf_pkg::CFG_DATA_W-1:0] write_data
);

  localparam int CW     = sbsf_pkg::COORD_WIDTH;
  localparam int OW     = sbsf_pkg::OPER_W;
  localparam int WW     = sbsf_pkg::WIDE_W;
  localparam int MW     = sbsf_pkg::MUL_W;
  localparam int PW     = sbsf_pkg::PROD_W;
  localparam int RW     = sbsf_pkg::RADIUS_W;
  localparam int SCALEW = PW - sbsf_pkg::FRAC_W;
  localparam logic signed [WW-1:0] CMAX_W = WW'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic signed [WW-1:0] CMIN_W = -CMAX_W - WW'(1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL    = 9'b000000010,
    ST_ADD    = 9'b000000100,
    ST_RSTART = 9'b000001000,
    ST_ROOT   = 9'b000010000,
    ST_GROW   = 9'b000100000,
    ST_SCALE  = 9'b001000000,
    ST_CLAMP  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t                       state;
  logic                         finishing;
  logic [1:0]                   comp;
  logic signed [CW-1:0]         col_q [3];
  logic signed [CW-1:0]         box_low [3];
  logic signed [CW-1:0]         box_high [3];
  logic                         seen_object;
  logic [PW-1:0]                square_sum;
  logic [PW-1:0]                prod;
  logic [RW-1:0]                radius_q;
  logic                         res_valid;
  logic signed [CW-1:0]         res_center [3];
  logic [RW-1:0]                res_radius;
  logic                         res_empty;

  sbsf_pkg::cfg_t               cfg;
  sbsf_pkg::root_stat_t         root_stat;
  logic [sbsf_pkg::ROOT_OUT_W-1:0] root_val;

  logic                         accept;
  logic                         out_free;
  logic signed [CW-1:0]         cur_col;
  logic signed [CW-1:0]         cur_low;
  logic signed [CW-1:0]         cur_high;
  logic [OW-1:0]                col_ext;
  logic [OW-1:0]                mag;
  logic [OW-1:0]                side;
  logic [OW-1:0]                oper;
  logic                         sq_ovf;
  logic [MW-1:0]                mul_a;
  logic [MW-1:0]                mul_b;
  logic [PW-1:0]                mul_full;
  logic [PW:0]                  sum_wide;
  logic [PW-1:0]                sum_sat;
  logic signed [WW-1:0]         col_w;
  logic signed [WW-1:0]         ext_w;
  logic signed [WW-1:0]         lo_raw;
  logic signed [WW-1:0]         hi_raw;
  logic signed [CW-1:0]         lo_c;
  logic signed [CW-1:0]         hi_c;
  logic signed [CW:0]           mid_sum [3];
  logic [SCALEW-1:0]            scaled;
  logic [SCALEW-1:0]            raised;
  logic [SCALEW-1:0]            lowered;

  sbsf_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  sbsf_root u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_RSTART),
    .operand (square_sum),
    .stat    (root_stat),
    .root    (root_val)
  );

  // Handshake
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !res_valid || result.ready;

  // Select the component under work
  assign cur_col  = col_q[comp];
  assign cur_low  = box_low[comp];
  assign cur_high = box_high[comp];

  // Magnitude of a column component, or a box side on finish
  assign col_ext = {{(OW - CW){cur_col[CW-1]}}, cur_col};
  assign mag     = col_ext[OW-1] ? (OW'(0) - col_ext) : col_ext;
  assign side    = {{(OW - CW){cur_high[CW-1]}}, cur_high}
                 - {{(OW - CW){cur_low[CW-1]}}, cur_low};
  assign oper    = finishing ? side : mag;
  assign sq_ovf  = |oper[OW-1:MW];

  // Shared multiplier: squares, then half-diagonal times margin gain
  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = MW'(root_val[sbsf_pkg::ROOT_OUT_W-1:1]);
      mul_b = MW'(cfg.margin_gain);
    end else begin
      mul_a = oper[MW-1:0];
      mul_b = oper[MW-1:0];
    end
  end
  assign mul_full = PW'(mul_a) * PW'(mul_b);

  // Saturating accumulate
  assign sum_wide = {1'b0, square_sum} + {1'b0, prod};
  assign sum_sat  = sum_wide[PW] ? {PW{1'b1}} : sum_wide[PW-1:0];

  // Object cube corners, clamped to the coordinate range
  assign col_w  = {{(WW - CW){cur_col[CW-1]}}, cur_col};
  assign ext_w  = WW'(root_val[sbsf_pkg::ROOT_OUT_W-1:1]);
  assign lo_raw = col_w - ext_w;
  assign hi_raw = col_w + ext_w;

  always_comb begin
    if (lo_raw > CMAX_W) begin
      lo_c = CMAX_W[CW-1:0];
    end else if (lo_raw < CMIN_W) begin
      lo_c = CMIN_W[CW-1:0];
    end else begin
      lo_c = lo_raw[CW-1:0];
    end
    if (hi_raw > CMAX_W) begin
      hi_c = CMAX_W[CW-1:0];
    end else if (hi_raw < CMIN_W) begin
      hi_c = CMIN_W[CW-1:0];
    end else begin
      hi_c = hi_raw[CW-1:0];
    end
  end

  // Box centers, floor of the midpoint
  for (genvar i = 0; i < 3; i++) begin : g_mid
    assign mid_sum[i] = {box_low[i][CW-1], box_low[i]} + {box_high[i][CW-1], box_high[i]};
  end

  // Radius: drop fraction bits of the product, raise to floor, lower to ceiling
  assign scaled  = prod[PW-1:sbsf_pkg::FRAC_W];
  assign raised  = (scaled < SCALEW'(cfg.radius_floor)) ? SCALEW'(cfg.radius_floor) : scaled;
  assign lowered = (raised > SCALEW'(cfg.radius_ceiling)) ? SCALEW'(cfg.radius_ceiling)
                                                          : raised;

  // Capture accepted column components
  always_ff @(posedge clk) begin
    if (accept) begin
      col_q[0] <= item.col_x;
      col_q[1] <= item.col_y;
      col_q[2] <= item.col_z;
    end
  end

  // Sequencer and scene state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      finishing   <= 1'b0;
      comp        <= '0;
      seen_object <= 1'b0;
      square_sum  <= '0;
      for (int i = 0; i < 3; i++) begin
        box_low[i]  <= '0;
        box_high[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            comp      <= '0;
            finishing <= (sbsf_pkg::op_t'(item.operation) == sbsf_pkg::OP_FINISH);
            if (sbsf_pkg::op_t'(item.operation) == sbsf_pkg::OP_FINISH) begin
              if (seen_object) begin
                square_sum <= '0;
                state      <= ST_MUL;
              end else begin
                state <= ST_EMIT;
              end
            end else if (item.column_index == sbsf_pkg::COL_TRANSLATION) begin
              state <= ST_RSTART;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          square_sum <= sum_sat;
          if (comp == 2'd2) begin
            comp  <= '0;
            state <= finishing ? ST_RSTART : ST_IDLE;
          end else begin
            comp  <= comp + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_RSTART: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_stat.done) begin
            comp  <= '0;
            state <= finishing ? ST_SCALE : ST_GROW;
          end
        end
        ST_GROW: begin
          if (!seen_object || lo_c < cur_low) begin
            box_low[comp] <= lo_c;
          end
          if (!seen_object || hi_c > cur_high) begin
            box_high[comp] <= hi_c;
          end
          if (comp == 2'd2) begin
            seen_object <= 1'b1;
            square_sum  <= '0;
            state       <= ST_IDLE;
          end else begin
            comp <= comp + 1'b1;
          end
        end
        ST_SCALE: begin
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the output register is free, then clear the scene
          if (out_free) begin
            seen_object <= 1'b0;
            square_sum  <= '0;
            for (int i = 0; i < 3; i++) begin
              box_low[i]  <= '0;
              box_high[i] <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Product register of the shared multiplier
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= sq_ovf ? {PW{1'b1}} : mul_full;
    end else if (state == ST_SCALE) begin
      prod <= mul_full;
    end
  end

  // Radius register: clamped value, or the empty-scene default
  always_ff @(posedge clk) begin
    if (state == ST_CLAMP) begin
      radius_q <= lowered[RW-1:0];
    end else if (accept && !seen_object) begin
      radius_q <= cfg.empty_radius;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      for (int i = 0; i < 3; i++) begin
        res_center[i] <= seen_object ? mid_sum[i][CW:1] : '0;
      end
      res_radius <= radius_q;
      res_empty  <= !seen_object;
    end
  end

  assign result.valid        = res_valid;
  assign result.center_x     = res_center[0];
  assign result.center_y     = res_center[1];
  assign result.center_z     = res_center[2];
  assign result.bound_radius = res_radius;
  assign result.scene_empty  = res_empty;

endmodule

// ===== hdl/sbsf_cfg.sv =====
// Configuration register file: radius limits, margin gain, empty radius.
`timescale 1ns / 1ps

module sbsf_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [sbsf_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [sbsf_pkg::CFG_DATA_W-1:0]     write_data,
  output sbsf_pkg::cfg_t                      cfg
);

  // Write the addressed register, masked to its width; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_floor   <= sbsf_pkg::FLOOR_RESET;
      cfg.radius_ceiling <= sbsf_pkg::CEILING_RESET;
      cfg.margin_gain    <= sbsf_pkg::GAIN_RESET;
      cfg.empty_radius   <= sbsf_pkg::EMPTY_RESET;
    end else if (write_enable) begin
      unique case (sbsf_pkg::cfg_reg_t'(reg_index))
        sbsf_pkg::CFG_RADIUS_FLOOR: begin
          cfg.radius_floor <= write_data[sbsf_pkg::RADIUS_W-1:0];
        end
        sbsf_pkg::CFG_RADIUS_CEILING: begin
          cfg.radius_ceiling <= write_data[sbsf_pkg::RADIUS_W-1:0];
        end
        sbsf_pkg::CFG_MARGIN_GAIN: begin
          cfg.margin_gain <= write_data[sbsf_pkg::GAIN_W-1:0];
        end
        sbsf_pkg::CFG_EMPTY_RADIUS: begin
          cfg.empty_radius <= write_data[sbsf_pkg::RADIUS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/sbsf_root.sv =====
// Iterative 64-bit integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module sbsf_root (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sbsf_pkg::ROOT_IN_W-1:0]      operand,
  output sbsf_pkg::root_stat_t                stat,
  output logic [sbsf_pkg::ROOT_OUT_W-1:0]     root
);

  logic [sbsf_pkg::ROOT_IN_W-1:0]  rem;
  logic [sbsf_pkg::ROOT_IN_W-1:0]  acc;
  logic [sbsf_pkg::ROOT_IN_W-1:0]  probe;
  logic [sbsf_pkg::ROOT_CNT_W-1:0] count;
  logic [sbsf_pkg::ROOT_IN_W-1:0]  trial;
  logic                            take;

  assign trial = acc + probe;
  assign take  = (rem >= trial);
  assign root  = acc[sbsf_pkg::ROOT_OUT_W-1:0];

  // Control: run for ROOT_STEPS steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      count <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        count     <= '0;
      end else if (stat.busy) begin
        count <= count + 1'b1;
        if (count == sbsf_pkg::ROOT_CNT_W'(sbsf_pkg::ROOT_STEPS - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract the trial value where it fits, shift the probe down
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= operand;
      acc   <= '0;
      probe <= sbsf_pkg::ROOT_IN_W'(1) << (sbsf_pkg::ROOT_IN_W - 2);
    end else if (stat.busy) begin
      if (take) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + probe;
      end else begin
        acc <= acc >> 1;
      end
      probe <= probe >> 2;
    end
  end

endmodule

// ===== hdl/sbsf_checker.sv =====
// Port-level checker for the scene bounds sphere fit block, with its bind.
`timescale 1ns / 1ps
`include "scene_bounds_sphere_fit_defines.svh"

module sbsf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   item_valid,
  input logic                                   item_ready,
  input logic                                   res_valid,
  input logic                                   res_ready,
  input logic signed [sbsf_pkg::COORD_WIDTH-1:0] center_x,
  input logic signed [sbsf_pkg::COORD_WIDTH-1:0] center_y,
  input logic signed [sbsf_pkg::COORD_WIDTH-1:0] center_z,
  input logic [sbsf_pkg::RADIUS_W-1:0]          bound_radius,
  input logic                                   scene_empty
);

  // A stalled result stays offered
  `SBSF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `SBSF_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(center_x) && $stable(center_y) && $stable(center_z) && $stable(bound_radius) && $stable(scene_empty), "result payload changed while stalled")

  // Every accepted item makes the block busy in the next cycle
  `SBSF_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "ready right after an accepted item")

  // An empty scene reports a zero center
  `SBSF_ASSERT_SAME(a_empty_center, res_valid && scene_empty, center_x == 0 && center_y == 0 && center_z == 0, "empty scene with nonzero center")

  // A new result only appears when the block was busy in the previous cycle
  `SBSF_ASSERT_SAME(a_result_after_work, $rose(res_valid), $past(!item_ready), "result appeared while idle")

endmodule

bind scene_bounds_sphere_fit sbsf_checker u_sbsf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .center_x     (result.center_x),
  .center_y     (result.center_y),
  .center_z     (result.center_z),
  .bound_radius (result.bound_radius),
  .scene_empty  (result.scene_empty)
);
